>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used in the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/tkmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkmp_pkg
// Types and constants shared by the terminal key and mouse report parser.
// ----------------------------------------------------------------------------
package tkmp_pkg;

	// Bytes with a meaning to the parser.
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_BRACKET   = 8'h5B;   // '['
	localparam logic [7:0] CH_LESS      = 8'h3C;   // '<'
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;   // ';'
	localparam logic [7:0] CH_PRESS     = 8'h4D;   // 'M'
	localparam logic [7:0] CH_RELEASE   = 8'h6D;   // 'm'
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;

	// Key codes.
	localparam logic [5:0] KEY_DIGIT_BASE = 6'd26;
	localparam logic [5:0] KEY_SPACE      = 6'd36;
	localparam logic [5:0] KEY_ENTER      = 6'd37;
	localparam logic [5:0] KEY_TAB        = 6'd38;
	localparam logic [5:0] KEY_BACKSPACE  = 6'd39;
	localparam logic [5:0] KEY_UNKNOWN    = 6'd40;

	// Event kinds.
	localparam logic EV_KEY   = 1'b0;
	localparam logic EV_MOUSE = 1'b1;

	// Mouse actions.
	localparam logic ACT_PRESS   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Mouse buttons as reported on the event.
	localparam logic [1:0] BTN_NONE   = 2'd0;
	localparam logic [1:0] BTN_LEFT   = 2'd1;
	localparam logic [1:0] BTN_MIDDLE = 2'd2;
	localparam logic [1:0] BTN_RIGHT  = 2'd3;

	// Button numbers as they appear in the report text.
	localparam int unsigned RPT_LEFT   = 0;
	localparam int unsigned RPT_MIDDLE = 1;
	localparam int unsigned RPT_RIGHT  = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} byte_item_t;

	typedef struct packed {
		logic        event_kind;
		logic [5:0]  key_id;
		logic        mouse_action;
		logic [1:0]  mouse_button;
		logic [15:0] mouse_x;
		logic [15:0] mouse_y;
	} event_item_t;

	// Classification of one byte, passed from the decoder to the parser.
	typedef struct packed {
		logic       is_esc;
		logic       is_bracket;
		logic       is_less;
		logic       is_semicolon;
		logic       is_final;
		logic       is_release;
		logic       is_digit;
		logic [3:0] digit;
		logic [5:0] key_id;
	} byte_class_t;

endpackage

>>> hw/rtl/tkmp_byte_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkmp_byte_decode
// Classifies one input byte and works out its key code.
// ----------------------------------------------------------------------------
module tkmp_byte_decode
	import tkmp_pkg::*;
(
	input  logic [7:0]  data_byte,
	output byte_class_t byte_class
);

	always_comb begin
		byte_class              = '0;
		byte_class.is_esc       = (data_byte == CH_ESC);
		byte_class.is_bracket   = (data_byte == CH_BRACKET);
		byte_class.is_less      = (data_byte == CH_LESS);
		byte_class.is_semicolon = (data_byte == CH_SEMICOLON);
		byte_class.is_final     = (data_byte == CH_PRESS) || (data_byte == CH_RELEASE);
		byte_class.is_release   = (data_byte == CH_RELEASE);
		byte_class.is_digit     = (data_byte inside {[CH_DIGIT_0:CH_DIGIT_9]});
		byte_class.digit        = 4'(data_byte - CH_DIGIT_0);

		case (data_byte) inside
			[CH_LOWER_A:CH_LOWER_Z]: begin
				byte_class.key_id = 6'(data_byte - CH_LOWER_A);
			end
			[CH_DIGIT_0:CH_DIGIT_9]: begin
				byte_class.key_id = KEY_DIGIT_BASE + 6'(data_byte - CH_DIGIT_0);
			end
			CH_SPACE: begin
				byte_class.key_id = KEY_SPACE;
			end
			CH_NEWLINE: begin
				byte_class.key_id = KEY_ENTER;
			end
			CH_TAB: begin
				byte_class.key_id = KEY_TAB;
			end
			CH_BACKSPACE: begin
				byte_class.key_id = KEY_BACKSPACE;
			end
			default: begin
				byte_class.key_id = KEY_UNKNOWN;
			end
		endcase
	end

endmodule

>>> hw/rtl/tkmp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkmp_parser
// Sequence state machine: holds the parse phase and the numbers of a mouse
// report, and forms the event that a byte gives.
// ----------------------------------------------------------------------------
module tkmp_parser
	import tkmp_pkg::*;
#(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic        end_of_buffer,
	input  byte_class_t byte_class,
	output logic        fire,
	output event_item_t event_item
);

	localparam int unsigned PROD_BITS = COORD_BITS + 4;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_ESC,
		PH_BRACKET,
		PH_BUTTON,
		PH_XCOORD,
		PH_YCOORD
	} phase_t;

	phase_t                phase_q, phase_d;
	logic                  seen_q, seen_d;
	logic [COORD_BITS-1:0] acc_q, acc_d;
	logic [1:0]            button_q, button_d;
	logic [15:0]           column_q, column_d;

	logic [PROD_BITS-1:0]  prod;
	logic [COORD_BITS-1:0] acc_sat;
	logic [1:0]            button_map;
	logic                  reprocess;

	// Decimal step: acc * 10 + digit, held at all ones on overflow.
	always_comb begin
		prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + PROD_BITS'(byte_class.digit);
		if (prod[PROD_BITS-1:COORD_BITS] != '0) begin
			acc_sat = '1;
		end else begin
			acc_sat = prod[COORD_BITS-1:0];
		end
	end

	always_comb begin
		if (acc_q == COORD_BITS'(RPT_LEFT)) begin
			button_map = BTN_LEFT;
		end else if (acc_q == COORD_BITS'(RPT_MIDDLE)) begin
			button_map = BTN_MIDDLE;
		end else if (acc_q == COORD_BITS'(RPT_RIGHT)) begin
			button_map = BTN_RIGHT;
		end else begin
			button_map = BTN_NONE;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		seen_d     = seen_q;
		acc_d      = acc_q;
		button_d   = button_q;
		column_d   = column_q;
		fire       = 1'b0;
		event_item = '0;
		reprocess  = 1'b0;

		case (phase_q)
			PH_ESC: begin
				if (byte_class.is_bracket) begin
					phase_d = PH_BRACKET;
				end else begin
					reprocess = 1'b1;
				end
			end
			PH_BRACKET: begin
				if (byte_class.is_less) begin
					phase_d = PH_BUTTON;
					seen_d  = 1'b0;
					acc_d   = '0;
				end else begin
					reprocess = 1'b1;
				end
			end
			PH_BUTTON, PH_XCOORD: begin
				if (byte_class.is_digit) begin
					acc_d  = acc_sat;
					seen_d = 1'b1;
				end else if (byte_class.is_semicolon && seen_q) begin
					if (phase_q == PH_BUTTON) begin
						button_d = button_map;
						phase_d  = PH_XCOORD;
					end else begin
						column_d = 16'(acc_q);
						phase_d  = PH_YCOORD;
					end
					seen_d = 1'b0;
					acc_d  = '0;
				end else begin
					reprocess = 1'b1;
				end
			end
			PH_YCOORD: begin
				if (byte_class.is_digit) begin
					acc_d  = acc_sat;
					seen_d = 1'b1;
				end else if (byte_class.is_final && seen_q) begin
					fire                    = 1'b1;
					event_item.event_kind   = EV_MOUSE;
					event_item.mouse_action = byte_class.is_release ? ACT_RELEASE : ACT_PRESS;
					event_item.mouse_button = button_q;
					event_item.mouse_x      = column_q;
					event_item.mouse_y      = 16'(acc_q);
					phase_d                 = PH_NORMAL;
					seen_d                  = 1'b0;
					acc_d                   = '0;
				end else begin
					reprocess = 1'b1;
				end
			end
			default: begin
				reprocess = 1'b1;
			end
		endcase

		// Normal mode, also for a byte that has just broken a sequence.
		if (reprocess) begin
			seen_d = 1'b0;
			acc_d  = '0;
			if (byte_class.is_esc) begin
				phase_d = PH_ESC;
			end else begin
				phase_d             = PH_NORMAL;
				fire                = 1'b1;
				event_item          = '0;
				event_item.event_kind = EV_KEY;
				event_item.key_id   = byte_class.key_id;
			end
		end

		if (end_of_buffer && (phase_d != PH_NORMAL)) begin
			phase_d = PH_NORMAL;
			seen_d  = 1'b0;
			acc_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NORMAL;
			seen_q   <= 1'b0;
			acc_q    <= '0;
			button_q <= BTN_NONE;
			column_q <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			seen_q   <= seen_d;
			acc_q    <= acc_d;
			button_q <= button_d;
			column_q <= column_d;
		end
	end

endmodule

>>> hw/rtl/terminal_key_and_sgr_mouse_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_key_and_sgr_mouse_parser
// Turns a stream of terminal input bytes into key press and mouse events.
// ----------------------------------------------------------------------------
// One byte beat goes in, and it gives at most one event beat out. A byte is
// held in the input register, classified and run through the sequence state
// machine, and any event it gives is written to the result register as the
// byte leaves the input register; the event is offered from the result
// register, and the block takes one byte in every cycle while the event side
// keeps up. The only thing that holds it back is a stalled result register:
// while an event waits there, the byte behind it waits in the input register
// and byte_stall rises. Plain bytes give key events; ESC starts a sequence
// and gives nothing; ESC [ < button ; x ; y M (or m) gives a mouse press (or
// release) event. A byte that breaks a sequence is handled again as an
// ordinary byte, and end_of_buffer drops whatever sequence is still open once
// its byte has been handled. Numbers saturate at 2^COORD_BITS - 1, and the
// event carries their low sixteen bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module terminal_key_and_sgr_mouse_parser
	import tkmp_pkg::*;
#(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        byte_valid,
	output logic        byte_stall,
	input  byte_item_t  byte_item,

	output logic        event_valid,
	input  logic        event_stall,
	output event_item_t event_item
);

	// Input register: the byte being worked on this cycle.
	logic        valid_s1;
	byte_item_t  item_s1;

	// Result register: the event on offer.
	logic        valid_s2;
	event_item_t event_s2;

	byte_class_t byte_class;
	logic        fire;
	event_item_t event_next;
	logic        advance;

	// The byte in stage one moves on when the result register is empty or is
	// being emptied in this same cycle.
	assign advance    = valid_s1 && (!valid_s2 || !event_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	tkmp_byte_decode u_decode (
		.data_byte  (item_s1.data_byte),
		.byte_class (byte_class)
	);

	tkmp_parser #(
		.COORD_BITS (COORD_BITS)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (advance),
		.end_of_buffer (item_s1.end_of_buffer),
		.byte_class    (byte_class),
		.fire          (fire),
		.event_item    (event_next)
	);

	// A byte that gives no event still leaves stage one, and then the result
	// register simply stays empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire;
		end else if (!event_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			event_s2 <= event_next;
		end
	end

	assign event_valid = valid_s2;
	assign event_item  = event_s2;

	// The byte side is held back only by an event that waits to be taken.
	`ASSERT_SAME(a_stall_cause, byte_stall, valid_s1 && valid_s2 && event_stall, "byte stall without a waiting event")

	// A byte that gives no event leaves no beat behind it.
	`ASSERT_NEXT(a_no_phantom, advance && !fire, !valid_s2, "event offered for a byte that gave none")

	// A key event carries a key code in range and no mouse coordinates.
	`ASSERT_SAME(a_key_clean, valid_s2 && (event_s2.event_kind == EV_KEY), (event_s2.key_id <= KEY_UNKNOWN) && (event_s2.mouse_x == 16'd0) && (event_s2.mouse_y == 16'd0), "malformed key event")

endmodule
